@@ hdl/nsr_pkg.sv @@
package nsr_pkg;

  // Fixed-point format of the input value
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  // Magnitude bits of a non-negative input
  localparam int X_W       = VALUE_W - 1;
  // Guess width: integer Newton from above never drops below isqrt(x << FRAC_BITS),
  // so every guess stays at or below max(x, (x + 2^FRAC_BITS) / 2) + 1.
  localparam int GUESS_W   = X_W + 1;
  // Dividend of one step is x << FRAC_BITS
  localparam int DVD_W     = X_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int ROOT_W    = 24;
  localparam int EPS_W     = 31;

  localparam int MAX_STEPS = 32;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  localparam logic [GUESS_W-1:0] ROOT_MAX = GUESS_W'((64'd1 << ROOT_W) - 64'd1);
  localparam logic [X_W-1:0]     ONE_FX   = X_W'(64'd1 << FRAC_BITS);

  // Handshake between control and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ hdl/newton_square_root.sv @@
// Negative, zero and one inputs go from input transfer straight to the finish state
// and then to the output register; other inputs first run Newton steps, each a start,
// a division over the 47 quotient bits, done and update, at most 32 steps.
// Throughput: one item at a time; a new item is taken once the previous one has
// left the iteration loop, while its result may still wait in the output register.
// Reset (synchronous, rst_n low): loop idle, output empty, epsilon back to 1.
module newton_square_root (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: epsilon in bits 30:0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // root[23:0]
  output logic [1:0]  out_tuser   // invalid[0], hit_limit[1]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [nsr_pkg::EPS_W-1:0]      eps_r;
  logic [nsr_pkg::X_W-1:0]        x_r, x_nxt;
  logic [nsr_pkg::GUESS_W-1:0]    last_r, last_nxt;
  logic [nsr_pkg::GUESS_W-1:0]    next_r, next_nxt;
  logic [nsr_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           start_r, start_nxt;
  logic [nsr_pkg::ROOT_W-1:0]     res_root_r, res_root_nxt;
  logic                           res_inv_r, res_inv_nxt;
  logic                           res_lim_r, res_lim_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic [nsr_pkg::ROOT_W-1:0]     out_root_r;
  logic                           out_inv_r, out_lim_r;

  nsr_pkg::div_req_t              div_req;
  nsr_pkg::div_sts_t              div_sts;
  logic [nsr_pkg::DVD_W-1:0]      quotient;
  logic [nsr_pkg::GUESS_W:0]      sum;
  logic [nsr_pkg::GUESS_W-1:0]    diff;
  logic [nsr_pkg::ROOT_W-1:0]     next_sat;
  logic                           in_xfer;
  logic                           out_free;

  assign div_req.start = start_r;

  nsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend ({x_r, nsr_pkg::FRAC_BITS'(0)}),
    .divisor  (last_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= nsr_pkg::EPS_W'(1);
    end else if (cfg_valid) begin
      eps_r <= cfg_data[nsr_pkg::EPS_W-1:0];
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // Newton update; the quotient is bounded by the guess range, upper bits are zero
  always_comb begin
    sum  = {1'b0, last_r} + {1'b0, quotient[nsr_pkg::GUESS_W-1:0]};
    diff = (last_r > next_r) ? (last_r - next_r) : (next_r - last_r);
    next_sat = (next_r > nsr_pkg::ROOT_MAX) ? nsr_pkg::ROOT_MAX[nsr_pkg::ROOT_W-1:0]
                                            : next_r[nsr_pkg::ROOT_W-1:0];
  end

  // Iteration sequencer
  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    last_nxt     = last_r;
    next_nxt     = next_r;
    step_nxt     = step_r;
    start_nxt    = 1'b0;
    res_root_nxt = res_root_r;
    res_inv_nxt  = res_inv_r;
    res_lim_nxt  = res_lim_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_inv_nxt = 1'b0;
          res_lim_nxt = 1'b0;
          if (in_tdata[nsr_pkg::VALUE_W-1]) begin
            // negative: no root
            res_root_nxt = '0;
            res_inv_nxt  = 1'b1;
            state_nxt    = S_FIN;
          end else if ((in_tdata[nsr_pkg::X_W-1:0] == '0) ||
                       (in_tdata[nsr_pkg::X_W-1:0] == nsr_pkg::ONE_FX)) begin
            res_root_nxt = in_tdata[nsr_pkg::ROOT_W-1:0];
            state_nxt    = S_FIN;
          end else begin
            x_nxt     = in_tdata[nsr_pkg::X_W-1:0];
            last_nxt  = {1'b0, in_tdata[nsr_pkg::X_W-1:0]};
            step_nxt  = nsr_pkg::STEP_W'(1);
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          next_nxt  = sum[nsr_pkg::GUESS_W:1];
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (diff <= {1'b0, eps_r}) begin
          res_root_nxt = next_sat;
          state_nxt    = S_FIN;
        end else if (step_r >= nsr_pkg::STEP_W'(nsr_pkg::MAX_STEPS)) begin
          res_root_nxt = next_sat;
          res_lim_nxt  = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          last_nxt  = next_r;
          step_nxt  = step_r + 1'b1;
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    last_r     <= last_nxt;
    next_r     <= next_nxt;
    step_r     <= step_nxt;
    res_root_r <= res_root_nxt;
    res_inv_r  <= res_inv_nxt;
    res_lim_r  <= res_lim_nxt;
    if ((state_r == S_FIN) && out_free) begin
      out_root_r <= res_root_r;
      out_inv_r  <= res_inv_r;
      out_lim_r  <= res_lim_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = {out_lim_r, out_inv_r};

  a_inv_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_inv_r) |-> (out_root_r == '0) && !out_lim_r)
    else $error("invalid result carries a root or limit flag");

  a_upd_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $past(div_sts.done))
    else $error("update without a finished division");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r <= nsr_pkg::STEP_W'(nsr_pkg::MAX_STEPS)))
    else $error("step count beyond cap");

endmodule

@@ hdl/nsr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// The dividend shifts out of the top of quo_r while quotient bits shift in below.
module nsr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nsr_pkg::div_req_t            req,
  input  logic [nsr_pkg::DVD_W-1:0]    dividend,
  input  logic [nsr_pkg::GUESS_W-1:0]  divisor,
  output nsr_pkg::div_sts_t            sts,
  output logic [nsr_pkg::DVD_W-1:0]    quotient
);

  logic [nsr_pkg::GUESS_W-1:0]   rem_r, rem_nxt;
  logic [nsr_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [nsr_pkg::GUESS_W-1:0]   dvs_r;
  logic [nsr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [nsr_pkg::GUESS_W:0]     trial;
  logic [nsr_pkg::GUESS_W:0]     diff;
  logic                          qbit;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem_r, quo_r[nsr_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[nsr_pkg::GUESS_W-1:0] : trial[nsr_pkg::GUESS_W-1:0];
    quo_nxt = {quo_r[nsr_pkg::DVD_W-2:0], qbit};
    cnt_nxt = cnt_r + 1'b1;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r && (cnt_r == nsr_pkg::DIV_CNT_W'(nsr_pkg::DVD_W - 1))) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Datapath; a zero divisor is replaced by one
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= (divisor == '0) ? nsr_pkg::GUESS_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a preceding shift cycle");

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r || done_r) |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule
